// ===== rtl/dlpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, widths and action codes for the DFA longest-prefix matcher.
// No dependencies.

package dlpm_pkg;

    localparam int CHAR_W    = 8;
    localparam int CLS_W     = 6;
    localparam int ST_W      = 6;
    localparam int NXT_W     = 7;
    localparam int LEN_W     = 16;
    localparam int ACT_W     = 3;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = ACT_W;
    localparam int M_TDATA_W = 24;

    localparam int              NUM_STATES_DEF     = 64;
    localparam int              NUM_CLASSES_DEF    = 64;
    localparam int              NUM_CHAR_CODES_DEF = 256;
    localparam longint unsigned MAX_LENGTH_DEF     = 65535;

    typedef enum logic [ACT_W-1:0] {
        ACT_WR_CLASS = 3'd0,
        ACT_WR_TRANS = 3'd1,
        ACT_WR_ACC   = 3'd2,
        ACT_MATCH    = 3'd3,
        ACT_END      = 3'd4
    } t_action;

    typedef struct packed {
        logic              vld;
        t_action           act;
        logic              code_bad;
        logic              wr_ok;
        logic              tgt_ok;
        logic [CHAR_W-1:0] chr;
        logic [CLS_W-1:0]  cls;
        logic [ST_W-1:0]   st;
        logic [ST_W-1:0]   tgt;
        logic              acc;
    } t_item;

    typedef struct packed {
        logic            hit;
        logic            is_end;
        logic            dead;
        logic [ST_W-1:0] tgt;
    } t_step;

    // width of the sweep address that covers every store
    function automatic int clr_width(input int ns, input int nc, input int ncc);
        int tt;
        begin
            tt = ns << $clog2(nc);
            return $clog2((tt > ncc) ? tt : ncc);
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dfa_longest_prefix_matcher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the DFA longest-prefix matcher: beat decode, store clearing, stages.
// Depends on dlpm_pkg, dlpm_class_map, dlpm_step, dlpm_accept.
//
//  Channel  | Dir | Signals                          | Content
//  ---------+-----+----------------------------------+------------------------------------
//  s_axis   | in  | tvalid, tready, tdata, tuser     | table loads, match bytes, end marks
//  m_axis   | out | tvalid, tready, tdata            | best length and early-stop flag
//
//  One beat per cycle while s_axis is not stalled: class read, transition read, flag read, result register.
//  The transition read data forms the next read address in the same cycle.
//  An end beat passes the class-map, step and accept-stage registers into the result register.
//  After reset a clearing pass sweeps max(NUM_STATES * 2**clog2(NUM_CLASSES),
//  NUM_CHAR_CODES) store addresses (4096 by default) and holds s_axis_tready low.
//  After that pass s_axis stalls only when an end beat reaches the last stage while the
//  previous result still waits on m_axis.

module dfa_longest_prefix_matcher import dlpm_pkg::*; #(
    parameter int              NUM_STATES     = NUM_STATES_DEF,
    parameter int              NUM_CLASSES    = NUM_CLASSES_DEF,
    parameter int              NUM_CHAR_CODES = NUM_CHAR_CODES_DEF,
    parameter longint unsigned MAX_LENGTH     = MAX_LENGTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // char_code[7:0], class_index[13:8], state_index[19:14], next_state[26:20],
    // accepting[27], zero[31:28]
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // action[2:0]
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // match_length[15:0], stopped_early[16], zero[23:17]
    output logic [M_TDATA_W-1:0]      m_axis_tdata
);

    localparam int CLR_W     = clr_width(NUM_STATES, NUM_CLASSES, NUM_CHAR_CODES);
    localparam int TT_DEPTH  = NUM_STATES << $clog2(NUM_CLASSES);
    localparam int CLR_DEPTH = (TT_DEPTH > NUM_CHAR_CODES) ? TT_DEPTH : NUM_CHAR_CODES;
    localparam int PW        = $clog2(MAX_LENGTH + 64'd1);

    logic             r_clr;
    logic [CLR_W-1:0] r_clr_cnt;
    logic             adv;
    logic             hold;
    t_item            item0, item1, item2;
    logic [CLS_W-1:0] cls1;
    t_step            step2;
    logic [PW-1:0]    pos2;
    logic             cls_ok, st_ok;
    logic [NXT_W-1:0] nxt;
    logic [LEN_W-1:0] out_len;
    logic             out_dead;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_cnt <= '0;
        end else if (r_clr) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == CLR_W'(CLR_DEPTH - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    assign adv           = !hold;
    assign s_axis_tready = adv && !r_clr;

    always_comb begin
        nxt            = s_axis_tdata[26:20];
        item0.vld      = s_axis_tvalid && s_axis_tready;
        item0.act      = t_action'(s_axis_tuser);
        item0.chr      = s_axis_tdata[7:0];
        item0.cls      = s_axis_tdata[13:8];
        item0.st       = s_axis_tdata[19:14];
        item0.tgt      = nxt[ST_W-1:0];
        item0.acc      = s_axis_tdata[27];
        item0.code_bad = 32'(item0.chr) >= NUM_CHAR_CODES;
        item0.tgt_ok   = !nxt[NXT_W-1] && (32'(nxt[ST_W-1:0]) < NUM_STATES);
        cls_ok         = 32'(item0.cls) < NUM_CLASSES;
        st_ok          = 32'(item0.st) < NUM_STATES;
        case (item0.act)
            ACT_WR_CLASS: item0.wr_ok = !item0.code_bad && cls_ok;
            ACT_WR_TRANS: item0.wr_ok = st_ok && cls_ok;
            ACT_WR_ACC:   item0.wr_ok = st_ok;
            default:      item0.wr_ok = 1'b0;
        endcase
    end

    dlpm_class_map #(
        .NUM_CHAR_CODES (NUM_CHAR_CODES),
        .CLR_W          (CLR_W)
    ) u_class (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_clr      (r_clr),
        .i_clr_addr (r_clr_cnt),
        .i_item     (item0),
        .o_item     (item1),
        .o_cls      (cls1)
    );

    dlpm_step #(
        .NUM_STATES  (NUM_STATES),
        .NUM_CLASSES (NUM_CLASSES),
        .MAX_LENGTH  (MAX_LENGTH),
        .CLR_W       (CLR_W)
    ) u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_clr      (r_clr),
        .i_clr_addr (r_clr_cnt),
        .i_item     (item1),
        .i_cls      (cls1),
        .o_item     (item2),
        .o_step     (step2),
        .o_pos      (pos2)
    );

    dlpm_accept #(
        .NUM_STATES (NUM_STATES),
        .MAX_LENGTH (MAX_LENGTH),
        .CLR_W      (CLR_W)
    ) u_accept (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_clr      (r_clr),
        .i_clr_addr (r_clr_cnt),
        .i_item     (item2),
        .i_step     (step2),
        .i_pos      (pos2),
        .i_m_tready (m_axis_tready),
        .o_hold     (hold),
        .o_tvalid   (m_axis_tvalid),
        .o_len      (out_len),
        .o_dead     (out_dead)
    );

    assign m_axis_tdata = {(M_TDATA_W - LEN_W - 1)'(0), out_dead, out_len};

endmodule

`default_nettype wire

// ===== rtl/dlpm_class_map.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Byte-to-class map memory and the first pipeline stage.
// Depends on dlpm_pkg.

module dlpm_class_map import dlpm_pkg::*; #(
    parameter int NUM_CHAR_CODES = NUM_CHAR_CODES_DEF,
    parameter int CLR_W          = clr_width(NUM_STATES_DEF, NUM_CLASSES_DEF,
                                             NUM_CHAR_CODES_DEF)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire logic             i_clr,
    input  wire logic [CLR_W-1:0] i_clr_addr,
    input  wire t_item            i_item,
    output t_item                 o_item,
    output logic [CLS_W-1:0]      o_cls
);

    localparam int AW = $clog2(NUM_CHAR_CODES);

    logic [CLS_W-1:0] r_mem [NUM_CHAR_CODES];
    logic [CLS_W-1:0] r_cls;
    t_item            r_item;

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            if (32'(i_clr_addr) < NUM_CHAR_CODES) begin
                r_mem[i_clr_addr[AW-1:0]] <= '0;
            end
        end else if (i_item.vld && i_item.act == ACT_WR_CLASS && i_item.wr_ok) begin
            r_mem[i_item.chr[AW-1:0]] <= i_item.cls;
        end
        if (i_adv && !i_item.code_bad) begin
            r_cls <= r_mem[i_item.chr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item <= '0;
        end else if (i_adv) begin
            r_item <= i_item;
        end
    end

    assign o_item = r_item;
    assign o_cls  = r_cls;

endmodule

`default_nettype wire

// ===== rtl/dlpm_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Transition table memory and the string state (state, length, freeze flag).
// Depends on dlpm_pkg.

module dlpm_step import dlpm_pkg::*; #(
    parameter int              NUM_STATES  = NUM_STATES_DEF,
    parameter int              NUM_CLASSES = NUM_CLASSES_DEF,
    parameter longint unsigned MAX_LENGTH  = MAX_LENGTH_DEF,
    parameter int              CLR_W       = clr_width(NUM_STATES_DEF, NUM_CLASSES_DEF,
                                                       NUM_CHAR_CODES_DEF)
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_adv,
    input  wire logic                                 i_clr,
    input  wire logic [CLR_W-1:0]                     i_clr_addr,
    input  wire t_item                                i_item,
    input  wire logic [CLS_W-1:0]                     i_cls,
    output t_item                                     o_item,
    output t_step                                     o_step,
    output logic [$clog2(MAX_LENGTH + 64'd1)-1:0]     o_pos
);

    localparam int SW       = $clog2(NUM_STATES);
    localparam int CW       = $clog2(NUM_CLASSES);
    localparam int TAW      = SW + CW;
    localparam int TT_DEPTH = NUM_STATES << CW;
    localparam int PW       = $clog2(MAX_LENGTH + 64'd1);

    logic [ST_W:0]   r_tt [TT_DEPTH];
    logic [ST_W:0]   r_rd;
    t_item           r_item;
    logic [ST_W-1:0] r_state, n_state;
    logic [PW-1:0]   r_pos,   n_pos;
    logic            r_dead,  n_dead;
    logic            n_hit;

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_dead  = r_dead;
        n_hit   = 1'b0;
        if (r_item.vld) begin
            case (r_item.act)
                ACT_MATCH: begin
                    if (!r_dead) begin
                        if (r_item.code_bad || !r_rd[ST_W]) begin
                            n_dead = 1'b1;
                        end else begin
                            n_state = r_rd[ST_W-1:0];
                            n_hit   = 1'b1;
                            if (r_pos != PW'(MAX_LENGTH)) begin
                                n_pos = r_pos + 1'b1;
                            end
                        end
                    end
                end
                ACT_END: begin
                    n_state = '0;
                    n_pos   = '0;
                    n_dead  = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // next state of the older beat feeds the read address of this one
    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            if (32'(i_clr_addr) < TT_DEPTH) begin
                r_tt[i_clr_addr[TAW-1:0]] <= '0;
            end
        end else if (i_item.vld && i_item.act == ACT_WR_TRANS && i_item.wr_ok) begin
            r_tt[{SW'(i_item.st), CW'(i_item.cls)}] <=
                i_item.tgt_ok ? {1'b1, i_item.tgt} : '0;
        end
        if (i_adv) begin
            r_rd <= r_tt[{SW'(n_state), CW'(i_cls)}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item  <= '0;
            r_state <= '0;
            r_pos   <= '0;
            r_dead  <= 1'b0;
        end else if (i_adv) begin
            r_item  <= i_item;
            r_state <= n_state;
            r_pos   <= n_pos;
            r_dead  <= n_dead;
        end
    end

    assign o_item        = r_item;
    assign o_step.hit    = n_hit;
    assign o_step.is_end = r_item.vld && r_item.act == ACT_END;
    assign o_step.dead   = r_dead;
    assign o_step.tgt    = n_state;
    assign o_pos         = n_pos;

endmodule

`default_nettype wire

// ===== rtl/dlpm_accept.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Accepting-flag memory, best-length register and the result output register.
// Depends on dlpm_pkg.

module dlpm_accept import dlpm_pkg::*; #(
    parameter int              NUM_STATES = NUM_STATES_DEF,
    parameter longint unsigned MAX_LENGTH = MAX_LENGTH_DEF,
    parameter int              CLR_W      = clr_width(NUM_STATES_DEF, NUM_CLASSES_DEF,
                                                      NUM_CHAR_CODES_DEF)
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_adv,
    input  wire logic                             i_clr,
    input  wire logic [CLR_W-1:0]                 i_clr_addr,
    input  wire t_item                            i_item,
    input  wire t_step                            i_step,
    input  wire logic [$clog2(MAX_LENGTH + 64'd1)-1:0] i_pos,
    input  wire logic                             i_m_tready,
    output logic                                  o_hold,
    output logic                                  o_tvalid,
    output logic [LEN_W-1:0]                      o_len,
    output logic                                  o_dead
);

    localparam int SW = $clog2(NUM_STATES);
    localparam int PW = $clog2(MAX_LENGTH + 64'd1);

    logic             r_acc [NUM_STATES];
    logic             r_flag;
    t_step            r_s3;
    logic [PW-1:0]    r_pos3;
    logic [PW-1:0]    r_best;
    logic             r_out_vld;
    logic [LEN_W-1:0] r_out_len;
    logic             r_out_dead;

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            if (32'(i_clr_addr) < NUM_STATES) begin
                r_acc[i_clr_addr[SW-1:0]] <= 1'b0;
            end
        end else if (i_item.vld && i_item.act == ACT_WR_ACC && i_item.wr_ok) begin
            r_acc[SW'(i_item.st)] <= i_item.acc;
        end
        if (i_adv) begin
            r_flag <= r_acc[SW'(i_step.tgt)];
            r_pos3 <= i_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3   <= '0;
            r_best <= '0;
        end else if (i_adv) begin
            r_s3 <= i_step;
            if (r_s3.is_end) begin
                r_best <= '0;
            end else if (r_s3.hit && r_flag) begin
                r_best <= r_pos3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_adv && r_s3.is_end) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && r_s3.is_end) begin
            r_out_len  <= LEN_W'(r_best);
            r_out_dead <= r_s3.dead;
        end
    end

    assign o_hold   = r_s3.is_end && r_out_vld && !i_m_tready;
    assign o_tvalid = r_out_vld;
    assign o_len    = r_out_len;
    assign o_dead   = r_out_dead;

endmodule

`default_nettype wire

// ===== rtl/dlpm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for the DFA longest-prefix matcher, bound to the top level.
// Depends on dlpm_pkg and dfa_longest_prefix_matcher.

module dlpm_checker import dlpm_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // clearing pass follows reset
    a_clr_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready during store clearing");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

endmodule

bind dfa_longest_prefix_matcher dlpm_checker u_dlpm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
